### design/fdp_pkg.sv
`timescale 1ns / 1ps

package fdp_pkg;

  // Record byte values and offsets.
  localparam logic [7:0] ByteEnd     = 8'h00;
  localparam logic [7:0] ByteDeleted = 8'he5;
  localparam logic [7:0] ByteSpace   = 8'h20;
  localparam logic [7:0] ByteKanjiE5 = 8'h05;
  localparam logic [4:0] OfsExt      = 5'h08;
  localparam logic [4:0] OfsAttr     = 5'h0b;
  localparam logic [4:0] OfsCluster  = 5'h1a;
  localparam logic [4:0] OfsSize     = 5'h1c;
  localparam logic [4:0] LastPos     = 5'h1f;

  typedef struct packed {
    logic [63:0] entry_name;
    logic [23:0] entry_ext;
    logic [7:0]  attr_byte;
    logic [15:0] start_cluster;
    logic [31:0] size_bytes;
    logic        end_of_dir;
  } fdp_result_t;

  typedef struct packed {
    logic        valid;
    fdp_result_t data;
  } fdp_res_beat_t;

endpackage

### design/fdp_if.sv
`timescale 1ns / 1ps

interface fdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] dir_byte;
  logic       start_of_dir;

  modport source (output valid, output dir_byte, output start_of_dir, input ready);
  modport sink   (input valid, input dir_byte, input start_of_dir, output ready);
endinterface

interface fdp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] entry_name;
  logic [23:0] entry_ext;
  logic [7:0]  attr_byte;
  logic [15:0] start_cluster;
  logic [31:0] size_bytes;
  logic        end_of_dir;

  modport source (output valid, output entry_name, output entry_ext, output attr_byte,
                  output start_cluster, output size_bytes, output end_of_dir,
                  input ready);
  modport sink   (input valid, input entry_name, input entry_ext, input attr_byte,
                  input start_cluster, input size_bytes, input end_of_dir,
                  output ready);
endinterface

### design/fdp_parse.sv
`timescale 1ns / 1ps

module fdp_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_start,
  input  logic                  q_space,
  output fdp_pkg::fdp_res_beat_t res_o
);
  import fdp_pkg::*;

  // Input register stage.
  logic       stg_valid_r, stg_valid_nxt;
  logic [7:0] stg_byte_r;
  logic       stg_start_r;
  logic       adv;

  // Record state and field collectors.
  logic [4:0]      record_pos_r, record_pos_nxt;
  logic            dir_done_r, dir_done_nxt;
  logic            skip_r, skip_nxt;
  logic [7:0][7:0] name_r, name_nxt;
  logic [2:0][7:0] ext_r, ext_nxt;
  logic [7:0]      attr_r, attr_nxt;
  logic [1:0][7:0] cluster_r, cluster_nxt;
  logic [3:0][7:0] size_r, size_nxt;

  logic [4:0] pos;
  logic       done_eff;
  logic       skip_eff;
  logic [7:0] name_val;
  fdp_res_beat_t res_nxt;

  assign adv      = stg_valid_r && q_space;
  assign in_ready = !stg_valid_r || adv;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_valid && in_ready) begin
      stg_valid_nxt = 1'b1;
    end else if (adv) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r  <= in_byte;
      stg_start_r <= in_start;
    end
  end

  // A start flag clears position, terminated mark and skip mark before the byte is used.
  assign pos      = stg_start_r ? '0 : record_pos_r;
  assign done_eff = stg_start_r ? 1'b0 : dir_done_r;

  always_comb begin
    name_val = (stg_byte_r == ByteSpace) ? 8'h00 : stg_byte_r;
    if (pos == '0 && stg_byte_r == ByteKanjiE5) begin
      name_val = ByteDeleted;
    end
  end

  always_comb begin
    record_pos_nxt = record_pos_r;
    dir_done_nxt   = done_eff;
    skip_nxt       = stg_start_r ? 1'b0 : skip_r;
    name_nxt       = name_r;
    ext_nxt        = ext_r;
    attr_nxt       = attr_r;
    cluster_nxt    = cluster_r;
    size_nxt       = size_r;
    res_nxt        = '0;
    skip_eff       = skip_nxt;

    if (stg_start_r) begin
      record_pos_nxt = '0;
    end

    if (!done_eff) begin
      record_pos_nxt = pos + 5'd1;
      if (pos == '0) begin
        skip_nxt = (stg_byte_r == ByteDeleted);
        skip_eff = skip_nxt;
      end
      if (pos == '0 && stg_byte_r == ByteEnd) begin
        dir_done_nxt              = 1'b1;
        record_pos_nxt            = '0;
        skip_nxt                  = skip_r && !stg_start_r;
        res_nxt.valid             = 1'b1;
        res_nxt.data.end_of_dir   = 1'b1;
      end else if (!skip_eff) begin
        // Every lane is written once per record, so no clear is needed at byte 0.
        if (pos < OfsExt) begin
          name_nxt[pos[2:0]] = name_val;
        end else if (pos < OfsAttr) begin
          ext_nxt[pos[1:0]] = stg_byte_r;
        end else if (pos == OfsAttr) begin
          attr_nxt = stg_byte_r;
        end else if (pos == OfsCluster || pos == OfsCluster + 5'd1) begin
          cluster_nxt[pos[0]] = stg_byte_r;
        end else if (pos >= OfsSize) begin
          size_nxt[pos[1:0]] = stg_byte_r;
        end
        if (pos == LastPos) begin
          res_nxt.valid              = 1'b1;
          res_nxt.data.entry_name    = name_nxt;
          res_nxt.data.entry_ext     = ext_nxt;
          res_nxt.data.attr_byte     = attr_nxt;
          res_nxt.data.start_cluster = cluster_nxt;
          res_nxt.data.size_bytes    = size_nxt;
          res_nxt.data.end_of_dir    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_pos_r <= '0;
      dir_done_r   <= 1'b0;
      skip_r       <= 1'b0;
    end else if (adv) begin
      record_pos_r <= record_pos_nxt;
      dir_done_r   <= dir_done_nxt;
      skip_r       <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      name_r    <= name_nxt;
      ext_r     <= ext_nxt;
      attr_r    <= attr_nxt;
      cluster_r <= cluster_nxt;
      size_r    <= size_nxt;
    end
  end

  always_comb begin
    res_o       = res_nxt;
    res_o.valid = res_nxt.valid && adv;
  end

`ifndef SYNTH
  a_done_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    dir_done_r |-> record_pos_r == '0)
    else $error("position moved while directory is terminated");

  a_end_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    (res_o.valid && res_o.data.end_of_dir) |=> dir_done_r)
    else $error("terminator result without terminated mark");

  a_entry_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_o.valid && !res_o.data.end_of_dir) |-> (record_pos_r == LastPos && !stg_start_r))
    else $error("entry result away from the last record byte");
`endif

endmodule

### design/fdp_out_q.sv
`timescale 1ns / 1ps

module fdp_out_q (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fdp_pkg::fdp_res_beat_t push_i,
  output logic                  space_o,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fdp_pkg::fdp_result_t  out_data
);
  import fdp_pkg::*;

  fdp_result_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign push      = push_i.valid;
  assign out_valid = count_r != 2'd0;
  assign pop       = out_valid && out_ready;
  // Space is taken from the count alone, so no path runs from out_ready to in_ready.
  assign space_o   = count_r != 2'd2;
  assign out_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_i.data;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != 2'd2)
    else $error("result pushed into a full queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count did not follow a push");
`endif

endmodule

### design/fat16_dir_record_parser_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// in_ch     in   dir_byte, start_of_dir (one directory byte)
// out_ch    out  entry_name, entry_ext, attr_byte, start_cluster, size_bytes, end_of_dir
//
// One byte is taken every cycle while the result queue has room; a byte passes an input
// register, the record logic and a two-deep result queue before it shows on out_ch.
// The record position counter steps once per accepted byte until the terminator.
// Reset (rst_n low, synchronous) clears the position, terminated and skip marks
// and empties the queue. A stalled out_ch fills the queue, and in_ch then
// holds ready low until a slot frees up.
module fat16_dir_record_parser_core (
  input  logic clk,
  input  logic rst_n,
  fdp_in_if.sink    in_ch,
  fdp_out_if.source out_ch
);
  import fdp_pkg::*;

  fdp_res_beat_t res_beat;
  fdp_result_t   q_data;
  logic          q_space;

  // Record parser: input register, position counter and field collectors.
  fdp_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.dir_byte),
    .in_start (in_ch.start_of_dir),
    .q_space  (q_space),
    .res_o    (res_beat)
  );

  // Result queue decouples the output handshake from the parser.
  fdp_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (res_beat),
    .space_o   (q_space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (q_data)
  );

  assign out_ch.entry_name    = q_data.entry_name;
  assign out_ch.entry_ext     = q_data.entry_ext;
  assign out_ch.attr_byte     = q_data.attr_byte;
  assign out_ch.start_cluster = q_data.start_cluster;
  assign out_ch.size_bytes    = q_data.size_bytes;
  assign out_ch.end_of_dir    = q_data.end_of_dir;

endmodule

### tb/sv/fat16_dir_record_parser_core_tb.sv
`timescale 1ns / 1ps

module fat16_dir_record_parser_core_tb;
  import fdp_pkg::*;

  // Receiver hold-off used to fill the result queue and stall the input side.
  localparam int HoldCycles = 160;
  localparam int SettleCycles = 12;

  typedef enum int {
    KindLive,
    KindKanji,
    KindDeleted,
    KindEnd,
    KindCut,
    KindNoise
  } rec_kind_t;

  // Tracks the parser state beat by beat and holds the entries it predicts.
  class dir_entry_tracker;
    logic [4:0]  pos;
    bit          done;
    bit          skipping;
    logic [63:0] name_bytes;
    logic [23:0] ext_bytes;
    logic [7:0]  attr_val;
    logic [15:0] cluster_val;
    logic [31:0] size_val;
    fdp_result_t pending_entries[$];
    int          predicted;
    int          errors;

    function new();
      pos = '0;
      done = 1'b0;
      skipping = 1'b0;
      name_bytes = '0;
      ext_bytes = '0;
      attr_val = '0;
      cluster_val = '0;
      size_val = '0;
      predicted = 0;
      errors = 0;
    endfunction

    function int pending();
      return pending_entries.size();
    endfunction

    // One accepted input beat.
    function void take_byte(logic [7:0] b, logic begin_dir);
      logic [4:0]  p;
      logic [7:0]  v;
      fdp_result_t entry;
      if (begin_dir) begin
        pos = '0;
        done = 1'b0;
        skipping = 1'b0;
      end
      if (done) return;
      p = pos;
      pos = p + 5'd1;
      if (p == 5'd0) begin
        if (b == ByteEnd) begin
          // Terminator: all payload fields zero, only the end flag set.
          done = 1'b1;
          pos = '0;
          entry = '0;
          entry.end_of_dir = 1'b1;
          pending_entries.push_back(entry);
          predicted++;
          return;
        end
        skipping = (b == ByteDeleted);
        name_bytes = '0;
        ext_bytes = '0;
        attr_val = '0;
        cluster_val = '0;
        size_val = '0;
      end
      if (skipping) return;
      if (p < OfsExt) begin
        v = (b == ByteSpace) ? 8'h00 : b;
        if (p == 5'd0 && b == ByteKanjiE5) v = ByteDeleted;
        name_bytes[8*p +: 8] = v;
      end else if (p < OfsAttr) begin
        ext_bytes[8*(p - OfsExt) +: 8] = b;
      end else if (p == OfsAttr) begin
        attr_val = b;
      end else if (p == OfsCluster || p == OfsCluster + 5'd1) begin
        cluster_val[8*(p - OfsCluster) +: 8] = b;
      end else if (p >= OfsSize) begin
        size_val[8*(p - OfsSize) +: 8] = b;
      end
      if (p == LastPos) begin
        entry.entry_name = name_bytes;
        entry.entry_ext = ext_bytes;
        entry.attr_byte = attr_val;
        entry.start_cluster = cluster_val;
        entry.size_bytes = size_val;
        entry.end_of_dir = 1'b0;
        pending_entries.push_back(entry);
        predicted++;
      end
    endfunction

    function void cmp_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", field, want, got);
        errors++;
      end
    endfunction

    // One accepted result beat, compared with the oldest prediction.
    function void match_entry(fdp_result_t got);
      fdp_result_t want;
      if (pending_entries.size() == 0) begin
        $error("entry: expected none, got %h", got);
        errors++;
        return;
      end
      want = pending_entries.pop_front();
      cmp_field("entry_name", want.entry_name, got.entry_name);
      cmp_field("entry_ext", 64'(want.entry_ext), 64'(got.entry_ext));
      cmp_field("attr_byte", 64'(want.attr_byte), 64'(got.attr_byte));
      cmp_field("start_cluster", 64'(want.start_cluster), 64'(got.start_cluster));
      cmp_field("size_bytes", 64'(want.size_bytes), 64'(got.size_bytes));
      cmp_field("end_of_dir", 64'(want.end_of_dir), 64'(got.end_of_dir));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  fdp_in_if  in_ch();
  fdp_out_if out_ch();

  fat16_dir_record_parser_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  dir_entry_tracker tracker;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  bit          need_start;
  int          bytes_sent;
  logic [7:0]  rec_buf [32];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Both monitors sample at the edge, so they see the values that were
  // present when the handshake happened.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      tracker.take_byte(in_ch.dir_byte, in_ch.start_of_dir);
    end
  end

  always @(posedge clk) begin
    fdp_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.entry_name = out_ch.entry_name;
      got.entry_ext = out_ch.entry_ext;
      got.attr_byte = out_ch.attr_byte;
      got.start_cluster = out_ch.start_cluster;
      got.size_bytes = out_ch.size_bytes;
      got.end_of_dir = out_ch.end_of_dir;
      tracker.match_entry(got);
    end
  end

  // Result-side ready. A hold request keeps ready low for a fixed stretch,
  // counted here, while the sender keeps offering beats.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one beat and returns at the edge where it is taken.
  task automatic send_byte(input logic [7:0] b, input logic begin_dir);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.dir_byte <= b;
    in_ch.start_of_dir <= begin_dir;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_rec(input bit begin_dir, input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(rec_buf[i], begin_dir && i == 0);
    end
    bytes_sent += len;
  endtask

  // Fills the record buffer. With random content, the name and extension
  // bytes are spaces about a third of the time.
  function automatic void fill_rec(input logic [7:0] first, input logic [7:0] fill,
                                   input bit use_random);
    rec_buf[0] = first;
    for (int i = 1; i < 32; i++) begin
      if (!use_random) rec_buf[i] = fill;
      else if (i < 11 && $urandom_range(2) == 0) rec_buf[i] = ByteSpace;
      else rec_buf[i] = 8'($urandom_range(255));
    end
  endfunction

  function automatic logic [7:0] live_first();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == ByteEnd || b == ByteDeleted);
    return b;
  endfunction

  // The edge after the last beat lets the input monitor note that beat
  // before the pending count is read.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed records with random content; the rest terminators,
  // cut records and loose bytes that break record alignment.
  task automatic run_random(input int min_bytes, input int min_results);
    int        first_bytes;
    int        first_results;
    int        pick;
    bit        begin_dir;
    rec_kind_t kind;
    first_bytes = bytes_sent;
    first_results = tracker.predicted;
    while (bytes_sent - first_bytes < min_bytes ||
           tracker.predicted - first_results < min_results) begin
      pick = $urandom_range(99);
      begin_dir = need_start || ($urandom_range(99) < 15);
      if (pick < 6) kind = KindNoise;
      else if (pick < 16) kind = KindEnd;
      else if (pick < 26) kind = KindCut;
      else if (pick < 38) kind = KindDeleted;
      else if (pick < 46) kind = KindKanji;
      else kind = KindLive;
      case (kind)
        KindNoise: begin
          for (int i = $urandom_range(1, 6); i > 0; i--) begin
            send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
            bytes_sent++;
          end
          need_start = 1'b1;
        end
        KindEnd: begin
          rec_buf[0] = ByteEnd;
          send_rec(begin_dir, 1);
          // The directory is closed: these bytes are dropped by the block.
          for (int i = $urandom_range(3); i > 0; i--) begin
            send_byte(8'($urandom_range(255)), 1'b0);
          end
          need_start = 1'b1;
        end
        KindCut: begin
          fill_rec(live_first(), 8'h00, 1'b1);
          send_rec(begin_dir, $urandom_range(1, 31));
          need_start = 1'b1;
        end
        KindDeleted: begin
          fill_rec(ByteDeleted, 8'h00, 1'b1);
          send_rec(begin_dir, 32);
          need_start = 1'b0;
        end
        KindKanji: begin
          fill_rec(ByteKanjiE5, 8'h00, 1'b1);
          send_rec(begin_dir, 32);
          need_start = 1'b0;
        end
        default: begin
          fill_rec(live_first(), 8'h00, 1'b1);
          send_rec(begin_dir, 32);
          need_start = 1'b0;
        end
      endcase
    end
  endtask

  initial begin
    tracker = new();
    hold_req = 1'b0;
    need_start = 1'b0;
    bytes_sent = 0;
    send_idle_pct = 17;
    recv_idle_pct = 51;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.dir_byte <= 8'h00;
    in_ch.start_of_dir <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first records come without any start flag, so the
    // position counter runs from its reset value and wraps between records.
    fill_rec(8'hff, 8'hff, 1'b0);
    send_rec(1'b0, 32);
    // A leading space becomes zero: every field of this entry is zero.
    fill_rec(ByteSpace, 8'h00, 1'b0);
    send_rec(1'b0, 32);
    // Leading 0x05 stands for 0xe5; the spaced name collapses to zeros while
    // the extension keeps its raw spaces.
    fill_rec(ByteKanjiE5, ByteSpace, 1'b0);
    send_rec(1'b0, 32);
    fill_rec(ByteDeleted, 8'h00, 1'b0);
    send_rec(1'b0, 32);
    // A record cut short by a start flag leaves no entry.
    fill_rec(8'h41, 8'h5a, 1'b0);
    send_rec(1'b0, 10);
    fill_rec(8'h41, ByteSpace, 1'b0);
    send_rec(1'b1, 32);
    // Terminator, bytes ignored after it, then a directory that ends at once.
    rec_buf[0] = ByteEnd;
    send_rec(1'b0, 1);
    send_byte(8'hff, 1'b0);
    send_byte(ByteEnd, 1'b0);
    rec_buf[0] = ByteEnd;
    send_rec(1'b1, 1);
    fill_rec(live_first(), 8'h00, 1'b1);
    send_rec(1'b1, 32);

    run_random(48, 1);

    // Back-pressure: the receiver holds off while a string of terminators,
    // each one a result, fills the block up; then the sender waits for all
    // results to come out.
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_byte(ByteEnd, 1'b1);
    end
    need_start = 1'b1;
    drain_results();

    send_idle_pct = 51;
    recv_idle_pct = 17;
    run_random(48, 1);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(48, 1);
    drain_results();

    repeat (SettleCycles) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
design/fdp_pkg.sv
design/fdp_if.sv
design/fdp_parse.sv
design/fdp_out_q.sv
design/fat16_dir_record_parser_core.sv
tb/sv/fat16_dir_record_parser_core_tb.sv
